### rtl/core/ehc_pkg.sv
`timescale 1ns / 1ps

package ehc_pkg;

   localparam int COUNT_W   = 16;
   localparam int PROD_W    = 25;
   localparam int QUOT_W    = 9;
   localparam int CHAN_W    = 8;
   localparam int DIST_W    = 6;
   localparam int SCALE_STAGES = 2;
   localparam int COLOR_STAGES = 2;
   localparam int LATENCY   = SCALE_STAGES + QUOT_W + COLOR_STAGES;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1000);
   localparam logic [QUOT_W-1:0]  HUE_TURN    = QUOT_W'(360);
   localparam logic [CHAN_W-1:0]  CHAN_MAX    = '1;

   // Pipeline control that travels beside each pixel
   typedef struct packed {
      logic valid;
      logic escaped;
      logic frame_end;
   } ehc_tag_type;

   // Which channel is full, which ramps, which is off
   typedef enum logic [2:0] {
      SECT_RED_GRN_UP = 3'd0,
      SECT_GRN_RED_DN = 3'd1,
      SECT_GRN_BLU_UP = 3'd2,
      SECT_BLU_GRN_DN = 3'd3,
      SECT_BLU_RED_UP = 3'd4,
      SECT_RED_BLU_DN = 3'd5
   } ehc_sector_type;

endpackage

### rtl/core/ehc_scale.sv
`timescale 1ns / 1ps

module ehc_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  ehc_pkg::ehc_tag_type              in_tag,
   input  logic [ehc_pkg::COUNT_W-1:0]       in_count,
   input  logic [ehc_pkg::COUNT_W-1:0]       limit,
   output ehc_pkg::ehc_tag_type              out_tag,
   output logic [ehc_pkg::PROD_W-1:0]        out_product
);
   import ehc_pkg::*;

   ehc_tag_type               clamp_tag_ff, clamp_tag_in;
   logic [COUNT_W-1:0]        clamp_ff, clamp_in;
   ehc_tag_type               prod_tag_ff, prod_tag_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [PROD_W-1:0]         wide;

   always_comb begin
      clamp_tag_in = in_tag;
      clamp_in     = (in_count > limit) ? limit : in_count;
   end

   // count * 360 as shifted adds: 256 + 64 + 32 + 8
   assign wide = PROD_W'(clamp_ff);

   always_comb begin
      prod_tag_in = clamp_tag_ff;
      prod_in     = (wide << 8) + (wide << 6) + (wide << 5) + (wide << 3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_tag_ff <= '0;
         prod_tag_ff  <= '0;
      end else begin
         clamp_tag_ff <= clamp_tag_in;
         prod_tag_ff  <= prod_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      clamp_ff <= clamp_in;
      prod_ff  <= prod_in;
   end

   assign out_tag     = prod_tag_ff;
   assign out_product = prod_ff;

endmodule

### rtl/core/ehc_div_step.sv
`timescale 1ns / 1ps

module ehc_div_step (
   input  logic                              clock,
   input  logic                              reset,
   input  ehc_pkg::ehc_tag_type              in_tag,
   input  logic [ehc_pkg::COUNT_W-1:0]       in_part,
   input  logic [ehc_pkg::QUOT_W-1:0]        in_bits,
   input  logic [ehc_pkg::COUNT_W-1:0]       divisor,
   output ehc_pkg::ehc_tag_type              out_tag,
   output logic [ehc_pkg::COUNT_W-1:0]       out_part,
   output logic [ehc_pkg::QUOT_W-1:0]        out_bits
);
   import ehc_pkg::*;

   ehc_tag_type               tag_ff, tag_in;
   logic [COUNT_W-1:0]        part_ff, part_in;
   logic [QUOT_W-1:0]         bits_ff, bits_in;
   logic [COUNT_W:0]          trial;
   logic [COUNT_W:0]          diff;
   logic                      fits;

   // Partial remainder stays below the divisor, so trial fits one extra bit
   always_comb begin
      trial   = {in_part, in_bits[QUOT_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      tag_in  = in_tag;
      part_in = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      // shift out a dividend bit, shift in a quotient bit
      bits_in = {in_bits[QUOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      bits_ff <= bits_in;
   end

   assign out_tag  = tag_ff;
   assign out_part = part_ff;
   assign out_bits = bits_ff;

endmodule

### rtl/core/ehc_color.sv
`timescale 1ns / 1ps

module ehc_color (
   input  logic                              clock,
   input  logic                              reset,
   input  ehc_pkg::ehc_tag_type              in_tag,
   input  logic [ehc_pkg::QUOT_W-1:0]        in_quot,
   output logic                              out_strobe,
   output logic [ehc_pkg::CHAN_W-1:0]        out_red,
   output logic [ehc_pkg::CHAN_W-1:0]        out_green,
   output logic [ehc_pkg::CHAN_W-1:0]        out_blue,
   output logic                              out_frame_end
);
   import ehc_pkg::*;

   ehc_tag_type               hue_tag_ff, hue_tag_in;
   ehc_sector_type            sect_ff, sect_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic                      valid_ff, valid_in;
   logic                      fe_ff, fe_in;
   logic [CHAN_W-1:0]         red_ff, red_in;
   logic [CHAN_W-1:0]         green_ff, green_in;
   logic [CHAN_W-1:0]         blue_ff, blue_in;
   logic [QUOT_W-1:0]         hue;
   logic [QUOT_W-1:0]         resid;
   logic [DIST_W+3:0]         ramp_wide;
   logic [CHAN_W-1:0]         ramp;

   // Stage A: fold hue, find sector and distance to the nearest primary
   always_comb begin
      hue        = (in_quot == HUE_TURN) ? '0 : in_quot;
      hue_tag_in = in_tag;
      if (hue < QUOT_W'(60)) begin
         sect_in = SECT_RED_GRN_UP;
      end else if (hue < QUOT_W'(120)) begin
         sect_in = SECT_GRN_RED_DN;
      end else if (hue < QUOT_W'(180)) begin
         sect_in = SECT_GRN_BLU_UP;
      end else if (hue < QUOT_W'(240)) begin
         sect_in = SECT_BLU_GRN_DN;
      end else if (hue < QUOT_W'(300)) begin
         sect_in = SECT_BLU_RED_UP;
      end else begin
         sect_in = SECT_RED_BLU_DN;
      end
      if (hue >= QUOT_W'(240)) begin
         resid = hue - QUOT_W'(240);
      end else if (hue >= QUOT_W'(120)) begin
         resid = hue - QUOT_W'(120);
      end else begin
         resid = hue;
      end
      if (resid <= QUOT_W'(60)) begin
         dist_in = resid[DIST_W-1:0];
      end else begin
         dist_in = DIST_W'(QUOT_W'(120) - resid);
      end
   end

   // Stage B: ramp = dist * 17 / 4, then route channels
   always_comb begin
      ramp_wide = {dist_ff, 4'b0000} + (DIST_W+4)'(dist_ff);
      ramp      = ramp_wide[DIST_W+3:2];
      valid_in  = hue_tag_ff.valid;
      fe_in     = hue_tag_ff.frame_end;
      red_in    = '0;
      green_in  = '0;
      blue_in   = '0;
      if (hue_tag_ff.escaped) begin
         case (sect_ff)
            SECT_RED_GRN_UP: begin
               red_in   = CHAN_MAX;
               green_in = ramp;
            end
            SECT_GRN_RED_DN: begin
               red_in   = ramp;
               green_in = CHAN_MAX;
            end
            SECT_GRN_BLU_UP: begin
               green_in = CHAN_MAX;
               blue_in  = ramp;
            end
            SECT_BLU_GRN_DN: begin
               green_in = ramp;
               blue_in  = CHAN_MAX;
            end
            SECT_BLU_RED_UP: begin
               red_in  = ramp;
               blue_in = CHAN_MAX;
            end
            default: begin
               red_in  = CHAN_MAX;
               blue_in = ramp;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_tag_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         hue_tag_ff <= hue_tag_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sect_ff  <= sect_in;
      dist_ff  <= dist_in;
      fe_ff    <= fe_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_strobe    = valid_ff;
   assign out_red       = red_ff;
   assign out_green     = green_ff;
   assign out_blue      = blue_ff;
   assign out_frame_end = fe_ff;

endmodule

### rtl/core/escape_count_hue_colorizer.sv
`timescale 1ns / 1ps

// Escape-count hue colorizer: one pixel in, one RGB byte triple out.
// Input: pulse start with req_escape_count, req_escaped and req_frame_end;
// a pixel transfers on every clock where start is high (busy stays low, so
// a new pixel may follow every cycle).
// Output: rsp_strobe is high for one cycle with rsp_red/green/blue and
// rsp_frame_end_out once the pixel has passed clamp and scale by 360
// (registered clamp, then registered product), the restoring divider by the
// iteration limit (one quotient bit per stage), then color mapping.
// Throughput is one pixel per clock; results come out in input order.
// The receiver has no backpressure: it must take each result as it appears.
// Configuration: csr_valid/csr_ready/csr_data write iteration_limit; write
// it only while no pixel is in flight. A limit of zero is stored as one.
// Reset (synchronous, active high) empties the pipeline, drops pixels in
// flight and loads an iteration limit of 1000.

module escape_count_hue_colorizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ehc_pkg::COUNT_W-1:0]       req_escape_count,
   input  logic                              req_escaped,
   input  logic                              req_frame_end,
   output logic                              rsp_strobe,
   output logic [ehc_pkg::CHAN_W-1:0]        rsp_red,
   output logic [ehc_pkg::CHAN_W-1:0]        rsp_green,
   output logic [ehc_pkg::CHAN_W-1:0]        rsp_blue,
   output logic                              rsp_frame_end_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ehc_pkg::COUNT_W-1:0]       csr_data
);
   import ehc_pkg::*;

   logic [COUNT_W-1:0]        limit_ff, limit_in;
   ehc_tag_type               entry_tag;
   ehc_tag_type               scale_tag;
   logic [PROD_W-1:0]         scale_product;
   ehc_tag_type               step_tag  [0:QUOT_W];
   logic [COUNT_W-1:0]        step_part [0:QUOT_W];
   logic [QUOT_W-1:0]         step_bits [0:QUOT_W];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = (csr_data == '0) ? COUNT_W'(1) : csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      entry_tag.valid     = start && !busy;
      entry_tag.escaped   = req_escaped;
      entry_tag.frame_end = req_frame_end;
   end

   ehc_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_tag      (entry_tag),
      .in_count    (req_escape_count),
      .limit       (limit_ff),
      .out_tag     (scale_tag),
      .out_product (scale_product)
   );

   // Top bits of the product are already below the limit
   assign step_tag[0]  = scale_tag;
   assign step_part[0] = scale_product[PROD_W-1:QUOT_W];
   assign step_bits[0] = scale_product[QUOT_W-1:0];

   for (genvar g = 0; g < QUOT_W; g++) begin : g_div
      ehc_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .in_tag   (step_tag[g]),
         .in_part  (step_part[g]),
         .in_bits  (step_bits[g]),
         .divisor  (limit_ff),
         .out_tag  (step_tag[g+1]),
         .out_part (step_part[g+1]),
         .out_bits (step_bits[g+1])
      );
   end

   ehc_color u_color (
      .clock         (clock),
      .reset         (reset),
      .in_tag        (step_tag[QUOT_W]),
      .in_quot       (step_bits[QUOT_W]),
      .out_strobe    (rsp_strobe),
      .out_red       (rsp_red),
      .out_green     (rsp_green),
      .out_blue      (rsp_blue),
      .out_frame_end (rsp_frame_end_out)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_strobe)
      else $error("pixel taken without a result after pipeline latency");

   a_frame_end_kept: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY (rsp_frame_end_out == $past(req_frame_end, LATENCY)))
      else $error("end-of-frame marker not carried with its pixel");

   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      (start && !req_escaped) |->
         ##LATENCY (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("pixel inside the set not black");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_red == '0 && rsp_green == '0 && rsp_blue == '0) ||
                      rsp_red == CHAN_MAX || rsp_green == CHAN_MAX ||
                      rsp_blue == CHAN_MAX))
      else $error("escaped pixel without a full channel");

endmodule

### dv/escape_count_hue_colorizer_test.sv
`timescale 1ns / 1ps

module escape_count_hue_colorizer_test;

   localparam int unsigned HUE_TURN_DEG   = 360;
   localparam int unsigned HUE_SECTOR_DEG = 60;
   localparam int unsigned ITEMS_PER_PHASE = 185;
   localparam int unsigned CYCLE_LIMIT    = 600000;

   typedef struct {
      logic [ehc_pkg::COUNT_W-1:0] count;
      logic                        escaped;
      logic                        frame_end;
      int unsigned                 gap;
   } pixel_type;

   typedef struct packed {
      logic [ehc_pkg::CHAN_W-1:0] red;
      logic [ehc_pkg::CHAN_W-1:0] green;
      logic [ehc_pkg::CHAN_W-1:0] blue;
      logic                       frame_end;
   } color_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [ehc_pkg::COUNT_W-1:0] req_escape_count = '0;
   logic                        req_escaped = 1'b0;
   logic                        req_frame_end = 1'b0;
   logic                        rsp_strobe;
   logic [ehc_pkg::CHAN_W-1:0]  rsp_red;
   logic [ehc_pkg::CHAN_W-1:0]  rsp_green;
   logic [ehc_pkg::CHAN_W-1:0]  rsp_blue;
   logic                        rsp_frame_end_out;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [ehc_pkg::COUNT_W-1:0] csr_data = '0;

   pixel_type                   pixel_queue[$];
   color_type                   color_queue[$];
   logic [ehc_pkg::COUNT_W-1:0] limit_model = ehc_pkg::LIMIT_RESET;
   int unsigned                 idle_left = 0;
   int unsigned                 mismatch_count = 0;
   int unsigned                 cycle_count = 0;

   escape_count_hue_colorizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_escape_count  (req_escape_count),
      .req_escaped       (req_escaped),
      .req_frame_end     (req_frame_end),
      .rsp_strobe        (rsp_strobe),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_frame_end_out (rsp_frame_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic color_type hue_color(logic [ehc_pkg::COUNT_W-1:0] count, logic escaped,
                                           logic frame_end, logic [ehc_pkg::COUNT_W-1:0] limit);
      int unsigned            lim;
      int unsigned            clamped;
      int unsigned            hue;
      int unsigned            slope;
      logic [ehc_pkg::CHAN_W-1:0] ramp;
      ehc_pkg::ehc_sector_type sector;
      color_type              col;
      col = '0;
      col.frame_end = frame_end;
      if (!escaped)
         return col;
      lim = (limit == 0) ? 1 : limit;
      clamped = (count > lim) ? lim : count;
      hue = ((clamped * HUE_TURN_DEG) / lim) % HUE_TURN_DEG;
      slope = hue % (2 * HUE_SECTOR_DEG);
      if (slope > HUE_SECTOR_DEG)
         slope = 2 * HUE_SECTOR_DEG - slope;
      ramp = ehc_pkg::CHAN_W'((slope * 17) >> 2);
      sector = ehc_pkg::ehc_sector_type'(3'(hue / HUE_SECTOR_DEG));
      case (sector)
         ehc_pkg::SECT_RED_GRN_UP: begin
            col.red = ehc_pkg::CHAN_MAX; col.green = ramp;
         end
         ehc_pkg::SECT_GRN_RED_DN: begin
            col.red = ramp; col.green = ehc_pkg::CHAN_MAX;
         end
         ehc_pkg::SECT_GRN_BLU_UP: begin
            col.green = ehc_pkg::CHAN_MAX; col.blue = ramp;
         end
         ehc_pkg::SECT_BLU_GRN_DN: begin
            col.green = ramp; col.blue = ehc_pkg::CHAN_MAX;
         end
         ehc_pkg::SECT_BLU_RED_UP: begin
            col.red = ramp; col.blue = ehc_pkg::CHAN_MAX;
         end
         default: begin
            col.red = ehc_pkg::CHAN_MAX; col.blue = ramp;
         end
      endcase
      return col;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_pixel(int unsigned count, logic escaped, logic frame_end, int unsigned gap);
      pixel_type px;
      px.count = ehc_pkg::COUNT_W'(count);
      px.escaped = escaped;
      px.frame_end = frame_end;
      px.gap = gap;
      pixel_queue.push_back(px);
   endtask

   // sample on the falling edge so queue and start are settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || start || color_queue.size() != 0);
   endtask

   // driver: one pixel per transfer, idle cycles after it as the item asks
   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else if (start && busy) begin
         // hold the pixel until it is taken
      end else if (idle_left > 0) begin
         start <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (pixel_queue.size() != 0) begin
         px = pixel_queue.pop_front();
         start <= 1'b1;
         req_escape_count <= px.count;
         req_escaped <= px.escaped;
         req_frame_end <= px.frame_end;
         idle_left <= px.gap;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: predict on each accepted pixel, check each strobed color
   always @(posedge clock) begin
      color_type want;
      if (reset) begin
         limit_model = ehc_pkg::LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready)
            limit_model = csr_data;
         if (start && !busy)
            color_queue.push_back(hue_color(req_escape_count, req_escaped, req_frame_end,
                                            limit_model));
         if (rsp_strobe) begin
            if (color_queue.size() == 0) begin
               $display("%0t unexpected color: got r %0d g %0d b %0d fe %0b", $time,
                        rsp_red, rsp_green, rsp_blue, rsp_frame_end_out);
               mismatch_count++;
            end else begin
               want = color_queue.pop_front();
               if (rsp_red !== want.red) begin
                  $display("%0t red: expected %0d, got %0d", $time, want.red, rsp_red);
                  mismatch_count++;
               end
               if (rsp_green !== want.green) begin
                  $display("%0t green: expected %0d, got %0d", $time, want.green, rsp_green);
                  mismatch_count++;
               end
               if (rsp_blue !== want.blue) begin
                  $display("%0t blue: expected %0d, got %0d", $time, want.blue, rsp_blue);
                  mismatch_count++;
               end
               if (rsp_frame_end_out !== want.frame_end) begin
                  $display("%0t frame_end_out: expected %0b, got %0b", $time,
                           want.frame_end, rsp_frame_end_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned limit_list[$];
      int unsigned lim_eff;
      int unsigned count;
      int unsigned roll;
      int          near;
      bit          calm;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset limit of 1000
      add_pixel(0, 1'b1, 1'b0, 0);
      add_pixel(1, 1'b1, 1'b0, 0);
      add_pixel(83, 1'b1, 1'b0, 1);
      add_pixel(167, 1'b1, 1'b0, 0);
      add_pixel(200, 1'b1, 1'b0, 0);
      add_pixel(334, 1'b1, 1'b0, 2);
      add_pixel(400, 1'b1, 1'b0, 0);
      add_pixel(500, 1'b1, 1'b0, 0);
      add_pixel(600, 1'b1, 1'b0, 0);
      add_pixel(667, 1'b1, 1'b0, 5);
      add_pixel(750, 1'b1, 1'b0, 0);
      add_pixel(834, 1'b1, 1'b0, 0);
      add_pixel(999, 1'b1, 1'b0, 0);
      add_pixel(1000, 1'b1, 1'b1, 0);
      add_pixel(1001, 1'b1, 1'b0, 0);
      add_pixel(65535, 1'b1, 1'b0, 0);
      add_pixel(16'h5555, 1'b1, 1'b0, 0);
      add_pixel(16'hAAAA, 1'b1, 1'b1, 0);
      add_pixel(500, 1'b0, 1'b0, 0);
      add_pixel(65535, 1'b0, 1'b1, 0);
      add_pixel(0, 1'b0, 1'b0, 30);
      add_pixel(250, 1'b1, 1'b1, 0);
      wait_drained();

      // extremes first, zero limit included, then random limits
      limit_list = '{1, 65535, 0, 360, 7, 3600};
      repeat (3) limit_list.push_back($urandom_range(1, 65535));
      limit_list.push_back($urandom_range(2, 40));

      foreach (limit_list[p]) begin
         @(posedge clock);
         csr_valid <= 1'b1;
         csr_data <= ehc_pkg::COUNT_W'(limit_list[p]);
         do @(posedge clock);
         while (!csr_ready);
         csr_valid <= 1'b0;

         lim_eff = (limit_list[p] == 0) ? 1 : limit_list[p];
         calm = 1'b0;
         for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 49) == 0)
               calm = !calm;
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
               count = $urandom_range(0, 65535);
            end else if (roll < 8) begin
               count = $urandom_range(0, lim_eff);
            end else if (roll == 8) begin
               near = int'(lim_eff) + $urandom_range(0, 4) - 2;
               count = (near < 0) ? 0 : (near > 65535) ? 65535 : near;
            end else begin
               case ($urandom_range(0, 2))
                  0: count = 0;
                  1: count = 65535;
                  default: count = $urandom_range(0, 15);
               endcase
            end
            add_pixel(count, $urandom_range(0, 9) < 8, $urandom_range(0, 9) == 0,
                      calm ? 0 : pick_gap());
         end
         wait_drained();
      end

      repeat (ehc_pkg::LATENCY + 4) @(posedge clock);
      if (color_queue.size() != 0) begin
         $display("%0t %0d expected colors never arrived", $time, color_queue.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
